// ===== rtl/core/som_chain_training_step_top_macros.svh =====
// assertion helpers for the kohonen chain block
`ifndef SOM_CHAIN_TRAINING_STEP_TOP_MACROS_SVH
`define SOM_CHAIN_TRAINING_STEP_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication on clk, quiet during reset
`define SOM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("som assertion failed");
// next-cycle implication on clk, quiet during reset
`define SOM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("som assertion failed");
`else
`define SOM_ASSERT_NOW(label, ante, cons)
`define SOM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/som_pkg.sv =====
package som_pkg;

	// field widths
	localparam int KIND_W = 2;
	localparam int IDX_W = 6;
	localparam int COORD_W = 16;
	localparam int DIST_W = 32;
	localparam int GAIN_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_COUNT = 6;
	localparam int NUM_NEURONS_DEF = 64;
	localparam int ONE_Q14 = 16384;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRAIN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	// gain register reset values, q16
	localparam logic [GAIN_W-1:0] GAIN_RESET [GAIN_COUNT] = '{
		17'd13107, 17'd6001, 17'd576, 17'd12, 17'd0, 17'd0
	};

	// one neuron weight as stored
	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} wpair_t;

	// operands of the shared multiplier pair
	typedef struct packed {
		logic signed [17:0] ax;
		logic signed [17:0] bx;
		logic signed [17:0] ay;
		logic signed [17:0] by;
	} mul_op_t;

	// registered products
	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
	} mul_res_t;

	// saturate to +-1.0 in q2.14
	function automatic logic signed [COORD_W-1:0] clamp_q14(input logic signed [20:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 21'(ONE_Q14)) begin
			r = 16'(ONE_Q14);
		end else if (v < -21'(ONE_Q14)) begin
			r = -16'(ONE_Q14);
		end else begin
			r = signed'(v[COORD_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/som_chain_training_step_top.sv =====
// One-dimensional Kohonen map of NUM_NEURONS neurons with 2-D Q2.14 weights. A load
// item writes a neuron and returns the clamped weight, a read item returns a stored
// weight, a train item finds the nearest neuron (lowest index on a tie) and pulls every
// neuron within five places of it toward the sample by the gain registers. After reset
// the weight memory is zeroed and no item is taken meanwhile; gain writes are taken at
// any time. A load or unused-kind item goes straight to the done state, a read passes
// through the read state, and a train runs a distance pass and an update pass that
// each stream one neuron a cycle through the single read port of the weight memory
// and the shared multiplier pair. The input is taken again as soon as the result is
// registered, even while it still waits on the output.
`include "som_chain_training_step_top_macros.svh"
module som_chain_training_step_top import som_pkg::*; #(
	parameter int NUM_NEURONS = NUM_NEURONS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [KIND_W-1:0]         kind,
	input  logic [IDX_W-1:0]          neuron_index,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          winner_index,
	output logic [DIST_W-1:0]         best_distance,
	output logic signed [COORD_W-1:0] weight_x,
	output logic signed [COORD_W-1:0] weight_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	localparam int AW = $clog2(NUM_NEURONS);
	localparam int CW = AW + 1;
	localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int DW = ((AW > 3) ? AW : 3) + 1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_UPD   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [GAIN_W-1:0] gain_q [GAIN_COUNT];

	logic signed [COORD_W-1:0] sx_q, sy_q;
	logic in_chain_q;
	logic [AW-1:0] win_q;
	logic [DIST_W-1:0] best_q;

	logic v_s1, v_s2;
	logic [AW-1:0] idx_s1, idx_s2;
	logic signed [COORD_W-1:0] wx_s2, wy_s2;

	logic [IDX_W-1:0] res_idx_q;
	logic [DIST_W-1:0] res_dist_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;

	logic out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;

	logic accept, issue, out_free, in_chain_in;
	logic [AW-1:0] addr_in;
	logic signed [COORD_W-1:0] cx_in, cy_in;

	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	wpair_t wr_data, rd_data;

	mul_op_t op;
	mul_res_t prod;

	logic signed [16:0] dx_s1, dy_s1;
	logic signed [DW-1:0] dd_s1;
	logic [DW-1:0] dabs_s1;
	logic [GAIN_W-1:0] gain_s1;
	logic [DIST_W-1:0] dsum_s2;
	logic signed [20:0] sumx_s2, sumy_s2;
	logic signed [COORD_W-1:0] nx_s2, ny_s2;

	// input side
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cx_in = clamp_q14(21'(coord_x));
	assign cy_in = clamp_q14(21'(coord_y));
	assign in_chain_in = XW'(neuron_index) < XW'(NUM_NEURONS);
	assign addr_in = AW'(neuron_index);
	assign issue = (state_q == ST_SCAN || state_q == ST_UPD) && (cnt_q < CW'(NUM_NEURONS));
	assign out_free = !out_valid_q || out_ready;

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_COUNT; i++) begin
				gain_q[i] <= GAIN_RESET[i];
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(GAIN_COUNT))) begin
			gain_q[cfg_index] <= cfg_data;
		end
	end

	// memory read port select
	always_comb begin
		rd_en = issue;
		rd_addr = cnt_q[AW-1:0];
		if (accept) begin
			rd_en = 1'b1;
			rd_addr = addr_in;
		end
	end

	// memory write port select
	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (accept && kind == KIND_LOAD && in_chain_in) begin
			wr_en = 1'b1;
			wr_addr = addr_in;
			wr_data.x = cx_in;
			wr_data.y = cy_in;
		end else if (state_q == ST_UPD && v_s2) begin
			wr_en = 1'b1;
			wr_addr = idx_s2;
			wr_data.x = nx_s2;
			wr_data.y = ny_s2;
		end
	end

	som_wmem #(
		.DEPTH (NUM_NEURONS),
		.AW    (AW)
	) u_wmem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1: differences and neighborhood gain
	assign dx_s1 = 17'(sx_q) - 17'(rd_data.x);
	assign dy_s1 = 17'(sy_q) - 17'(rd_data.y);
	assign dd_s1 = signed'(DW'(idx_s1)) - signed'(DW'(win_q));
	assign dabs_s1 = dd_s1[DW-1] ? DW'(-dd_s1) : DW'(dd_s1);

	always_comb begin
		gain_s1 = '0;
		if (dabs_s1 < DW'(GAIN_COUNT)) begin
			gain_s1 = gain_q[dabs_s1[2:0]];
		end
	end

	// operands: squares while scanning, gain times difference while updating
	always_comb begin
		op.ax = 18'(dx_s1);
		op.ay = 18'(dy_s1);
		op.bx = 18'(dx_s1);
		op.by = 18'(dy_s1);
		if (state_q == ST_UPD) begin
			op.bx = 18'(gain_s1);
			op.by = 18'(gain_s1);
		end
	end

	som_mul u_mul (
		.clk (clk),
		.op  (op),
		.res (prod)
	);

	// stage 2: distance sum and moved weight
	assign dsum_s2 = DIST_W'(prod.x) + DIST_W'(prod.y);
	assign sumx_s2 = 21'(wx_s2) + 21'(prod.x >>> 16);
	assign sumy_s2 = 21'(wy_s2) + 21'(prod.y >>> 16);
	assign nx_s2 = clamp_q14(sumx_s2);
	assign ny_s2 = clamp_q14(sumy_s2);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[AW-1:0] == AW'(NUM_NEURONS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (kind == KIND_TRAIN) begin
							state_q <= ST_SCAN;
						end else if (kind == KIND_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						cnt_q <= '0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample, search and result registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		idx_s2 <= idx_s1;
		wx_s2 <= rd_data.x;
		wy_s2 <= rd_data.y;
		if (accept) begin
			sx_q <= cx_in;
			sy_q <= cy_in;
			in_chain_q <= in_chain_in;
			res_idx_q <= neuron_index;
			res_dist_q <= '0;
			res_x_q <= '0;
			res_y_q <= '0;
			if (kind == KIND_LOAD && in_chain_in) begin
				res_x_q <= cx_in;
				res_y_q <= cy_in;
			end
		end
		if (state_q == ST_READ && in_chain_q) begin
			res_x_q <= rd_data.x;
			res_y_q <= rd_data.y;
		end
		// running minimum, first neuron always taken
		if (state_q == ST_SCAN && v_s2) begin
			if (idx_s2 == '0 || dsum_s2 < best_q) begin
				best_q <= dsum_s2;
				win_q <= idx_s2;
			end
		end
		if (state_q == ST_UPD && v_s2 && idx_s2 == win_q) begin
			res_x_q <= nx_s2;
			res_y_q <= ny_s2;
		end
		if (state_q == ST_UPD && !issue && !v_s1 && !v_s2) begin
			res_idx_q <= IDX_W'(win_q);
			res_dist_q <= best_q;
		end
		// output register takes the finished result
		if (state_q == ST_DONE && out_free) begin
			out_idx_q <= res_idx_q;
			out_dist_q <= res_dist_q;
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign winner_index = out_idx_q;
	assign best_distance = out_dist_q;
	assign weight_x = out_x_q;
	assign weight_y = out_y_q;

	// the memory is only read while distances are measured
	`SOM_ASSERT_NOW(a_no_write_in_scan, state_q == ST_SCAN, !wr_en)
	// winner stays inside the chain during the update pass
	`SOM_ASSERT_NOW(a_win_in_chain, state_q == ST_UPD, CW'(win_q) < CW'(NUM_NEURONS))
	// pipeline only carries neurons during the two passes
	`SOM_ASSERT_NOW(a_pipe_in_pass, v_s1 || v_s2, state_q == ST_SCAN || state_q == ST_UPD)
	// an accepted item closes the input in the following cycle
	`SOM_ASSERT_NEXT(a_busy_after_transfer, accept, !in_ready)

endmodule

// ===== rtl/core/som_wmem.sv =====
module som_wmem import som_pkg::*; #(
	parameter int DEPTH = NUM_NEURONS_DEF,
	parameter int AW = $clog2(NUM_NEURONS_DEF)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  wpair_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output wpair_t        rd_data
);

	wpair_t mem_q [DEPTH];
	wpair_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/som_mul.sv =====
module som_mul import som_pkg::*; (
	input  logic     clk,
	input  mul_op_t  op,
	output mul_res_t res
);

	mul_res_t res_q;

	// two signed 18x18 products, one per coordinate
	always_ff @(posedge clk) begin
		res_q.x <= op.ax * op.bx;
		res_q.y <= op.ay * op.by;
	end

	assign res = res_q;

endmodule

// ===== tb/som_chain_training_step_top_tb.sv =====
module som_chain_training_step_top_tb;
	import som_pkg::*;

	// unused item kind and gain write addresses that map to no register
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 11;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_CYCLES = 1200;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_TOP = 17'h1ffff;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} chain_op_t;

	typedef struct {
		logic [IDX_W-1:0] winner;
		logic [DIST_W-1:0] sq_distance;
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
	} neuron_reply_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [IDX_W-1:0] neuron_index = '0;
	logic signed [COORD_W-1:0] coord_x = '0;
	logic signed [COORD_W-1:0] coord_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] winner_index;
	logic [DIST_W-1:0] best_distance;
	logic signed [COORD_W-1:0] weight_x;
	logic signed [COORD_W-1:0] weight_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	// shadow copy of the chain and its gains
	logic signed [COORD_W-1:0] chain_x [NUM_NEURONS_DEF];
	logic signed [COORD_W-1:0] chain_y [NUM_NEURONS_DEF];
	logic [GAIN_W-1:0] gain_q [GAIN_COUNT];

	chain_op_t queued_ops [$];
	neuron_reply_t predicted_replies [$];
	chain_op_t offered;
	int queued_count = 0;
	int accepted_count = 0;
	int replies_seen = 0;
	int fail_count = 0;
	int in_idle_max = 10;
	int out_idle_max = 10;
	int in_wait = 0;
	int out_wait = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	som_chain_training_step_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.neuron_index(neuron_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.winner_index(winner_index),
		.best_distance(best_distance),
		.weight_x(weight_x),
		.weight_y(weight_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// saturate to +-1.0 in q2.14
	function automatic logic signed [COORD_W-1:0] limit_unit(input longint v);
		if (v > ONE_Q14) begin
			return COORD_W'(ONE_Q14);
		end else if (v < -ONE_Q14) begin
			return COORD_W'(-ONE_Q14);
		end
		return COORD_W'(v);
	endfunction

	// pull one coordinate toward the sample, floor of the q16 product
	function automatic logic signed [COORD_W-1:0] pull_coord(
		input logic signed [COORD_W-1:0] w,
		input logic signed [COORD_W-1:0] s,
		input logic [GAIN_W-1:0] g
	);
		longint p;
		p = longint'(g) * (longint'(s) - longint'(w));
		return limit_unit(longint'(w) + (p >>> 16));
	endfunction

	// apply one op to the shadow chain and return the reply it gives
	function automatic neuron_reply_t step_chain(input chain_op_t op);
		neuron_reply_t r;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		longint dx;
		longint dy;
		longint d;
		longint best;
		int win;
		int gap;
		logic [GAIN_W-1:0] g;
		sx = limit_unit(longint'(op.cx));
		sy = limit_unit(longint'(op.cy));
		r.winner = op.idx;
		r.sq_distance = '0;
		r.wx = '0;
		r.wy = '0;
		case (op.kind)
			KIND_LOAD: begin
				chain_x[op.idx] = sx;
				chain_y[op.idx] = sy;
				r.wx = sx;
				r.wy = sy;
			end
			KIND_READ: begin
				r.wx = chain_x[op.idx];
				r.wy = chain_y[op.idx];
			end
			KIND_TRAIN: begin
				// nearest neuron, first one wins a tie
				best = 0;
				win = 0;
				for (int i = 0; i < NUM_NEURONS_DEF; i++) begin
					dx = longint'(sx) - longint'(chain_x[i]);
					dy = longint'(sy) - longint'(chain_y[i]);
					d = dx * dx + dy * dy;
					if (i == 0 || d < best) begin
						best = d;
						win = i;
					end
				end
				// neighborhood update around the winner
				for (int i = 0; i < NUM_NEURONS_DEF; i++) begin
					gap = (i > win) ? i - win : win - i;
					g = (gap < GAIN_COUNT) ? gain_q[gap] : '0;
					chain_x[i] = pull_coord(chain_x[i], sx, g);
					chain_y[i] = pull_coord(chain_y[i], sy, g);
				end
				r.winner = IDX_W'(win);
				r.sq_distance = DIST_W'(best);
				r.wx = chain_x[win];
				r.wy = chain_y[win];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string field, input longint want,
		input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// sender: offers queued ops with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_replies.push_back(step_chain(offered));
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (in_wait > 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else if (queued_ops.size() > 0) begin
					offered = queued_ops.pop_front();
					kind <= offered.kind;
					neuron_index <= offered.idx;
					coord_x <= offered.cx;
					coord_y <= offered.cy;
					in_valid <= 1'b1;
					in_wait = $urandom_range(0, in_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transfer, stalls at random, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		neuron_reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					$display("%0t: unexpected reply, winner %0d distance %0d weight %0d %0d",
						$time, winner_index, best_distance, weight_x, weight_y);
					fail_count++;
				end else begin
					want = predicted_replies.pop_front();
					compare_field("winner_index", want.winner, winner_index);
					compare_field("best_distance", want.sq_distance, best_distance);
					compare_field("weight_x", want.wx, weight_x);
					compare_field("weight_y", want.wy, weight_y);
				end
				replies_seen++;
				if (replies_seen == PRESSURE_AT) begin
					hold_left = PRESSURE_CYCLES;
				end else begin
					out_wait = $urandom_range(0, out_idle_max);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("som_chain_training_step_top_tb failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_op(input logic [KIND_W-1:0] k, input int idx, input int x, input int y);
		chain_op_t op;
		op.kind = k;
		op.idx = IDX_W'(idx);
		op.cx = COORD_W'(x);
		op.cy = COORD_W'(y);
		queued_ops.push_back(op);
		queued_count++;
	endtask

	function automatic int random_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return int'(signed'(COORD_W'($urandom())));
		end else if (pick == 1) begin
			case ($urandom_range(0, 2))
				0: return ONE_Q14;
				1: return -ONE_Q14;
				default: return 0;
			endcase
		end
		return int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_ONE;
			2: return GAIN_W'($urandom());
			default: return GAIN_W'($urandom_range(0, GAIN_ONE));
		endcase
	endfunction

	// one gain register transfer
	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx < GAIN_COUNT) begin
			gain_q[idx] = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || predicted_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// random ops: mostly loads and trains so the chain keeps moving
	task automatic run_phase(input int count, input int in_max, input int out_max);
		int pick;
		logic [KIND_W-1:0] k;
		in_idle_max = in_max;
		out_idle_max = out_max;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				k = KIND_LOAD;
			end else if (pick < 70) begin
				k = KIND_TRAIN;
			end else if (pick < 96) begin
				k = KIND_READ;
			end else begin
				k = KIND_SPARE;
			end
			queue_op(k, $urandom_range(0, NUM_NEURONS_DEF - 1), random_coord(), random_coord());
		end
		wait_drained();
	endtask

	task automatic write_all_gains(input logic [GAIN_W-1:0] val);
		for (int r = 0; r < GAIN_COUNT; r++) begin
			write_gain(CFG_IDX_W'(r), val);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_NEURONS_DEF; i++) begin
			chain_x[i] = '0;
			chain_y[i] = '0;
		end
		for (int r = 0; r < GAIN_COUNT; r++) begin
			gain_q[r] = GAIN_RESET[r];
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed ops under the reset gains
		queue_op(KIND_READ, 0, 0, 0);
		queue_op(KIND_READ, NUM_NEURONS_DEF - 1, 0, 0);
		// all neurons at zero: tie across the whole chain
		queue_op(KIND_TRAIN, 17, 0, 0);
		queue_op(KIND_SPARE, 42, 1234, -1234);
		queue_op(KIND_LOAD, 0, ONE_Q14, ONE_Q14);
		queue_op(KIND_LOAD, NUM_NEURONS_DEF - 1, -ONE_Q14, -ONE_Q14);
		// out-of-range coordinates are saturated
		queue_op(KIND_LOAD, 5, 32767, -32768);
		queue_op(KIND_LOAD, 10, ONE_Q14 + 1, -ONE_Q14 - 1);
		queue_op(KIND_LOAD, 11, -1, 1);
		queue_op(KIND_READ, 5, 0, 0);
		queue_op(KIND_READ, 10, 0, 0);
		queue_op(KIND_TRAIN, 0, ONE_Q14, -ONE_Q14);
		queue_op(KIND_TRAIN, 63, -ONE_Q14, -ONE_Q14);
		queue_op(KIND_TRAIN, 0, -32768, 32767);
		// two neurons exactly on the sample: lower index wins
		queue_op(KIND_LOAD, 20, 8000, 8000);
		queue_op(KIND_LOAD, 21, 8000, 8000);
		queue_op(KIND_TRAIN, 3, 8000, 8000);
		queue_op(KIND_READ, 21, 0, 0);
		queue_op(KIND_READ, 22, 0, 0);
		queue_op(KIND_TRAIN, 0, ONE_Q14, ONE_Q14);
		queue_op(KIND_READ, NUM_NEURONS_DEF - 1, 0, 0);
		queue_op(KIND_LOAD, NUM_NEURONS_DEF - 1, 0, 0);
		queue_op(KIND_READ, NUM_NEURONS_DEF - 2, 0, 0);
		queue_op(KIND_SPARE, NUM_NEURONS_DEF - 1, -1, -1);
		wait_drained();

		// zero gains: training must leave the chain alone, no idling
		write_all_gains('0);
		run_phase(40, 0, 0);

		// widest gains, and writes to unmapped addresses
		write_all_gains(GAIN_TOP);
		write_gain(REG_SPARE_LO, GAIN_W'($urandom()));
		write_gain(REG_SPARE_HI, GAIN_W'($urandom()));
		run_phase(60, 10, 10);

		// unity gain everywhere
		write_all_gains(GAIN_ONE);
		run_phase(60, 3, 10);

		// back to the reset gains; this phase also carries the long hold-off
		for (int r = 0; r < GAIN_COUNT; r++) begin
			write_gain(CFG_IDX_W'(r), GAIN_RESET[r]);
		end
		run_phase(280, 10, 10);

		// random gain settings with mixed idling
		for (int p = 0; p < 3; p++) begin
			for (int r = 0; r < GAIN_COUNT; r++) begin
				write_gain(CFG_IDX_W'(r), random_gain());
			end
			run_phase(190, (p == 1) ? 0 : 10, (p == 1) ? 0 : 10);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("som_chain_training_step_top_tb passed");
		end else begin
			$display("som_chain_training_step_top_tb failed");
		end
		$finish;
	end

endmodule

// ===== som_chain_training_step_top.f =====
+incdir+rtl/core
rtl/core/som_pkg.sv
rtl/core/som_wmem.sv
rtl/core/som_mul.sv
rtl/core/som_chain_training_step_top.sv
tb/som_chain_training_step_top_tb.sv
